>>> hw/rtl/jpke_pkg.sv
package jpke_pkg;

  // fixed field widths
  localparam int unsigned ButtonW   = 32;
  localparam int unsigned AxisW     = 16;
  localparam int unsigned MotionW   = 32;
  localparam int unsigned SrcW      = 6;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned BtnCountW = 6;
  localparam int unsigned AxCountW  = 5;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned ScaleW    = 24;

  localparam int unsigned DirectionCount = 16;
  localparam int unsigned DigitalAxes    = 4;
  localparam int unsigned BallAxes       = 6;

  // change bits: buttons low, directions above
  localparam int unsigned KeyEvents = ButtonW + DirectionCount;
  localparam int unsigned KeyIdxW   = $clog2(KeyEvents);

  localparam int unsigned ProdW     = AxisW + ScaleW;
  localparam int unsigned QuotW     = ProdW - 16;

  localparam logic [AxisW-1:0] HatFwd   = 16'd0;
  localparam logic [AxisW-1:0] HatRight = 16'd9000;
  localparam logic [AxisW-1:0] HatBack  = 16'd18000;
  localparam logic [AxisW-1:0] HatLeft  = 16'd27000;

  localparam int unsigned HatFwdBit   = 12;
  localparam int unsigned HatBackBit  = 13;
  localparam int unsigned HatRightBit = 14;
  localparam int unsigned HatLeftBit  = 15;

  localparam logic [ThrW-1:0]   ThresholdReset = 16'd4915;
  localparam logic [ScaleW-1:0] BallScaleReset = 24'd1311;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUTTON_COUNT,
    CFG_AXIS_COUNT,
    CFG_HAS_HAT,
    CFG_THRESHOLD,
    CFG_BALL_SCALE
  } cfg_reg_e;

  typedef enum logic {
    EV_KEY,
    EV_MOTION
  } event_kind_e;

  // one classified sample, handed from front to back
  typedef struct packed {
    logic [KeyEvents-1:0] chg;
    logic [KeyEvents-1:0] val;
    logic                 mot;
    logic [MotionW-1:0]   mx;
    logic [MotionW-1:0]   my;
  } job_t;

endpackage

>>> hw/rtl/jpke_front.sv
module jpke_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [jpke_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [jpke_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [jpke_pkg::ButtonW-1:0]         buttons_i,
  input  logic [jpke_pkg::AxisW-1:0]           axis_x_i,
  input  logic [jpke_pkg::AxisW-1:0]           axis_y_i,
  input  logic [jpke_pkg::AxisW-1:0]           axis_z_i,
  input  logic [jpke_pkg::AxisW-1:0]           axis_r_i,
  input  logic [jpke_pkg::AxisW-1:0]           axis_u_i,
  input  logic [jpke_pkg::AxisW-1:0]           axis_v_i,
  input  logic [jpke_pkg::AxisW-1:0]           hat_angle_i,
  output logic                                 job_push_o,
  output jpke_pkg::job_t                       job_o,
  input  logic                                 job_full_i
);
  import jpke_pkg::*;

  logic [BtnCountW-1:0] button_count_q;
  logic [AxCountW-1:0]  axis_count_q;
  logic                 has_hat_q;
  logic [ThrW-1:0]      threshold_q;
  logic [ScaleW-1:0]    ball_scale_q;

  logic [ButtonW-1:0]        prev_btn_q;
  logic [DirectionCount-1:0] prev_dir_q;

  logic                      s1_vld_q, s1_vld_d;
  logic [KeyEvents-1:0]      chg_q, chg_d;
  logic [KeyEvents-1:0]      val_q, val_d;
  logic [ProdW-1:0]          prod_u_q, prod_u_d, prod_v_q, prod_v_d;
  logic                      neg_u_q, neg_v_q, ball_q, ball_d;

  logic                      accept, s1_go, useful, mot;
  logic [ButtonW-1:0]        btn_en, btn_chg;
  logic [DirectionCount-1:0] dirs;
  logic [AxisW-1:0]          axis_dig [DigitalAxes];
  logic signed [AxisW+1:0]   off, thr_s;
  logic [AxisW-1:0]          mag_u, mag_v;
  logic [QuotW-1:0]          q_u, q_v;

  assign axis_dig[0] = axis_x_i;
  assign axis_dig[1] = axis_y_i;
  assign axis_dig[2] = axis_z_i;
  assign axis_dig[3] = axis_r_i;

  // classify the incoming sample
  always_comb begin
    thr_s = $signed({2'b00, threshold_q});
    off   = '0;
    dirs  = '0;
    for (int i = 0; i < ButtonW; i++) begin
      btn_en[i] = button_count_q > BtnCountW'(i);
    end
    btn_chg = (buttons_i ^ prev_btn_q) & btn_en;
    for (int i = 0; i < DigitalAxes; i++) begin
      off = $signed({2'b00, axis_dig[i]}) - $signed(18'sd32768);
      if (axis_count_q > AxCountW'(i)) begin
        if (off < -thr_s) begin
          dirs[2*i] = 1'b1;
        end else if (off > thr_s) begin
          dirs[2*i+1] = 1'b1;
        end
      end
    end
    if (has_hat_q) begin
      if (hat_angle_i == HatFwd) begin
        dirs[HatFwdBit] = 1'b1;
      end else if (hat_angle_i == HatBack) begin
        dirs[HatBackBit] = 1'b1;
      end else if (hat_angle_i == HatRight) begin
        dirs[HatRightBit] = 1'b1;
      end else if (hat_angle_i == HatLeft) begin
        dirs[HatLeftBit] = 1'b1;
      end
    end
    chg_d = {dirs ^ prev_dir_q, btn_chg};
    val_d = {dirs, buttons_i};
    // magnitude of the offset from centre
    mag_u = axis_u_i[AxisW-1] ? {1'b0, axis_u_i[AxisW-2:0]}
                              : AxisW'(17'd32768 - {1'b0, axis_u_i});
    mag_v = axis_v_i[AxisW-1] ? {1'b0, axis_v_i[AxisW-2:0]}
                              : AxisW'(17'd32768 - {1'b0, axis_v_i});
    prod_u_d = ProdW'(mag_u) * ProdW'(ball_scale_q);
    prod_v_d = ProdW'(mag_v) * ProdW'(ball_scale_q);
    ball_d   = axis_count_q >= AxCountW'(BallAxes);
  end

  // second stage: sign and hand over
  always_comb begin
    q_u = prod_u_q[ProdW-1:16];
    q_v = prod_v_q[ProdW-1:16];
    mot = ball_q && ((q_u != '0) || (q_v != '0));
    useful = (chg_q != '0) || mot;
    job_o.chg = chg_q;
    job_o.val = val_q;
    job_o.mot = mot;
    job_o.mx  = neg_u_q ? MotionW'(0) - MotionW'(q_u) : MotionW'(q_u);
    job_o.my  = neg_v_q ? MotionW'(0) - MotionW'(q_v) : MotionW'(q_v);
    job_push_o = s1_vld_q && useful && !job_full_i;
    s1_go      = s1_vld_q && (!useful || !job_full_i);
    full_o     = s1_vld_q && !s1_go;
    accept     = push_i && !full_o;
    s1_vld_d   = accept || (s1_vld_q && !s1_go);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q <= '0;
      axis_count_q   <= '0;
      has_hat_q      <= 1'b0;
      threshold_q    <= ThresholdReset;
      ball_scale_q   <= BallScaleReset;
      prev_btn_q     <= '0;
      prev_dir_q     <= '0;
      s1_vld_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BUTTON_COUNT: button_count_q <= cfg_wdata_i[BtnCountW-1:0];
          CFG_AXIS_COUNT:   axis_count_q   <= cfg_wdata_i[AxCountW-1:0];
          CFG_HAS_HAT:      has_hat_q      <= cfg_wdata_i[0];
          CFG_THRESHOLD:    threshold_q    <= cfg_wdata_i[ThrW-1:0];
          CFG_BALL_SCALE:   ball_scale_q   <= cfg_wdata_i[ScaleW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_btn_q <= buttons_i;
        prev_dir_q <= dirs;
      end
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chg_q    <= chg_d;
      val_q    <= val_d;
      prod_u_q <= prod_u_d;
      prod_v_q <= prod_v_d;
      neg_u_q  <= !axis_u_i[AxisW-1];
      neg_v_q  <= !axis_v_i[AxisW-1];
      ball_q   <= ball_d;
    end
  end

endmodule

>>> hw/rtl/jpke_fifo.sv
module jpke_fifo #(
  parameter int unsigned Depth = jpke_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jpke_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output jpke_pkg::job_t data_o,
  output logic           empty_o
);
  import jpke_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

>>> hw/rtl/jpke_back.sv
module jpke_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              job_empty_i,
  input  jpke_pkg::job_t                    job_i,
  output logic                              job_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic                              event_kind_o,
  output logic [jpke_pkg::SrcW-1:0]         source_index_o,
  output logic                              pressed_o,
  output logic signed [jpke_pkg::MotionW-1:0] motion_x_o,
  output logic signed [jpke_pkg::MotionW-1:0] motion_y_o,
  output logic                              last_o
);
  import jpke_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e               state_q, state_d;
  logic [KeyIdxW-1:0]   idx_q, idx_d;
  logic [KeyEvents-1:0] rem_q, rem_d, val_q, val_d;
  logic                 mot_q, mot_d;
  logic [MotionW-1:0]   mx_q, mx_d, my_q, my_d;

  logic                 out_vld_q, out_vld_d;
  event_kind_e          out_kind_q, out_kind_d;
  logic [SrcW-1:0]      out_src_q, out_src_d;
  logic                 out_prs_q, out_prs_d;
  logic [MotionW-1:0]   out_mx_q, out_mx_d, out_my_q, out_my_d;
  logic                 out_last_q, out_last_d;

  logic [KeyEvents-1:0] bit_sel, rem_clr;
  logic                 out_free, key_last;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    val_d      = val_q;
    mot_d      = mot_q;
    mx_d       = mx_q;
    my_d       = my_q;
    out_vld_d  = out_vld_q && !pop_i;
    out_kind_d = out_kind_q;
    out_src_d  = out_src_q;
    out_prs_d  = out_prs_q;
    out_mx_d   = out_mx_q;
    out_my_d   = out_my_q;
    out_last_d = out_last_q;
    job_pop_o  = 1'b0;
    out_free   = !out_vld_q || pop_i;
    bit_sel    = KeyEvents'(1) << idx_q;
    rem_clr    = rem_q & ~bit_sel;
    key_last   = (rem_clr == '0) && !mot_q;
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          rem_d     = job_i.chg;
          val_d     = job_i.val;
          mot_d     = job_i.mot;
          mx_d      = job_i.mx;
          my_d      = job_i.my;
          idx_d     = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rem_q == '0) begin
          if (!mot_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_vld_d  = 1'b1;
            out_kind_d = EV_MOTION;
            out_src_d  = '0;
            out_prs_d  = 1'b0;
            out_mx_d   = mx_q;
            out_my_d   = my_q;
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if ((rem_q & bit_sel) == '0) begin
          idx_d = idx_q + 1'b1;
        end else if (out_free) begin
          idx_d      = idx_q + 1'b1;
          rem_d      = rem_clr;
          out_vld_d  = 1'b1;
          out_kind_d = EV_KEY;
          out_src_d  = SrcW'(idx_q);
          out_prs_d  = val_q[idx_q];
          out_mx_d   = '0;
          out_my_d   = '0;
          out_last_d = key_last;
          if (key_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      rem_q      <= '0;
      val_q      <= '0;
      mot_q      <= 1'b0;
      mx_q       <= '0;
      my_q       <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= EV_KEY;
      out_src_q  <= '0;
      out_prs_q  <= 1'b0;
      out_mx_q   <= '0;
      out_my_q   <= '0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      val_q      <= val_d;
      mot_q      <= mot_d;
      mx_q       <= mx_d;
      my_q       <= my_d;
      out_vld_q  <= out_vld_d;
      out_kind_q <= out_kind_d;
      out_src_q  <= out_src_d;
      out_prs_q  <= out_prs_d;
      out_mx_q   <= out_mx_d;
      out_my_q   <= out_my_d;
      out_last_q <= out_last_d;
    end
  end

  assign empty_o        = !out_vld_q;
  assign event_kind_o   = out_kind_q;
  assign source_index_o = out_src_q;
  assign pressed_o      = out_prs_q;
  assign motion_x_o     = $signed(out_mx_q);
  assign motion_y_o     = $signed(out_my_q);
  assign last_o         = out_last_q;

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && rem_q == '0 && !mot_q) |=> state_q == ST_IDLE)
    else $error("scan did not finish on empty job");
  a_motion_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == EV_MOTION) |->
      (out_src_q == '0 && !out_prs_q && out_last_q))
    else $error("malformed motion event");
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q == EV_KEY) |->
      (out_src_q <= SrcW'(KeyEvents - 1) && out_mx_q == '0 && out_my_q == '0))
    else $error("malformed key event");
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && out_free && rem_q != '0 && (rem_q & bit_sel) != '0
      && key_last) |=> state_q == ST_IDLE)
    else $error("back stayed busy after last event");

endmodule

>>> hw/rtl/joystick_poll_to_key_events.sv
// joystick poll to key events
//
// input channel: a poll sample (button mask, six axes, hat angle) is taken on
// a rising edge with push high and full low. result channel: while empty is
// low the oldest event is on the result ports; pop transfers it.
// the front stage classifies a sample (threshold compares, hat decode, change
// masks, ball scaling multiply) and drops it into a short job queue; the back
// scans the 48 change bits one per cycle (a set bit waits while the event
// register is held), buttons first, then directions, then the optional motion
// event, and flags the final one as last. a sample is registered in the front
// stage, pushed into the queue, loaded into the back's scan registers and then
// into the event register. the back takes a new job only once its scan is
// done; the front keeps accepting samples while the queue has room.
// samples that change nothing produce no events and cost the back nothing.
// a stalled receiver (pop low) holds the event register; the back waits, the
// queue fills, then full rises and the front holds its sample.
// reset clears previous button and direction masks, empties the queue and
// loads register defaults (threshold 4915, ball scale 1311, counts zero).
// configuration writes take effect on the next edge; write only while idle.
module joystick_poll_to_key_events #(
  parameter int unsigned QueueDepth = jpke_pkg::QueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jpke_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [jpke_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  logic [jpke_pkg::ButtonW-1:0]        buttons_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_x_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_y_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_z_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_r_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_u_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_v_i,
  input  logic [jpke_pkg::AxisW-1:0]          hat_angle_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                event_kind_o,
  output logic [jpke_pkg::SrcW-1:0]           source_index_o,
  output logic                                pressed_o,
  output logic signed [jpke_pkg::MotionW-1:0] motion_x_o,
  output logic signed [jpke_pkg::MotionW-1:0] motion_y_o,
  output logic                                last_o
);
  import jpke_pkg::*;

  // job queue between classification and event emission
  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  jpke_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .buttons_i   (buttons_i),
    .axis_x_i    (axis_x_i),
    .axis_y_i    (axis_y_i),
    .axis_z_i    (axis_z_i),
    .axis_r_i    (axis_r_i),
    .axis_u_i    (axis_u_i),
    .axis_v_i    (axis_v_i),
    .hat_angle_i (hat_angle_i),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .job_full_i  (job_full)
  );

  jpke_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // one event register on the result side decouples the receiver
  jpke_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_empty_i    (job_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .event_kind_o   (event_kind_o),
    .source_index_o (source_index_o),
    .pressed_o      (pressed_o),
    .motion_x_o     (motion_x_o),
    .motion_y_o     (motion_y_o),
    .last_o         (last_o)
  );

endmodule

>>> bench/jpke_event_checker.sv
module jpke_event_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [jpke_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [jpke_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                push,
  input  logic                                full,
  input  logic [jpke_pkg::ButtonW-1:0]        buttons_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_x_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_y_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_z_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_r_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_u_i,
  input  logic [jpke_pkg::AxisW-1:0]          axis_v_i,
  input  logic [jpke_pkg::AxisW-1:0]          hat_angle_i,
  input  logic                                empty,
  input  logic                                pop,
  input  logic                                event_kind_o,
  input  logic [jpke_pkg::SrcW-1:0]           source_index_o,
  input  logic                                pressed_o,
  input  logic signed [jpke_pkg::MotionW-1:0] motion_x_o,
  input  logic signed [jpke_pkg::MotionW-1:0] motion_y_o,
  input  logic                                last_o,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import jpke_pkg::*;

  localparam int               AxisCentre = 32768;
  localparam logic [AxisW-1:0] HatCentred = 16'hFFFF;
  localparam int               MaxReports = 10;

  typedef struct packed {
    event_kind_e        kind;
    logic [SrcW-1:0]    src;
    logic               pressed;
    logic [MotionW-1:0] mx;
    logic [MotionW-1:0] my;
    logic               last;
  } key_event_t;

  // register mirror
  logic [BtnCountW-1:0] button_count_q;
  logic [AxCountW-1:0]  axis_count_q;
  logic                 has_hat_q;
  logic [ThrW-1:0]      threshold_q;
  logic [ScaleW-1:0]    ball_scale_q;

  // sample history
  logic [ButtonW-1:0]        prev_buttons_q;
  logic [DirectionCount-1:0] prev_dirs_q;

  key_event_t events_due[$];
  int         fails;

  function automatic int axis_offset(input logic [AxisW-1:0] raw);
    return int'(raw) - AxisCentre;
  endfunction

  // magnitude times Q8.16 scale, truncated toward zero
  function automatic logic [MotionW-1:0] scale_ball(input logic [AxisW-1:0] raw);
    int                 off;
    longint unsigned    mag;
    longint unsigned    prod;
    logic [MotionW-1:0] q;
    off  = axis_offset(raw);
    mag  = (off < 0) ? longint'(-off) : longint'(off);
    prod = (mag * longint'(ball_scale_q)) >> 16;
    q    = MotionW'(prod);
    return (off < 0) ? -q : q;
  endfunction

  function automatic key_event_t key_event(input int src, input logic pressed);
    key_event_t ev;
    ev         = '0;
    ev.kind    = EV_KEY;
    ev.src     = SrcW'(src);
    ev.pressed = pressed;
    return ev;
  endfunction

  function automatic void decode_poll(input logic [ButtonW-1:0] btn,
                                      input logic [AxisW-1:0] ax, ay, az, ar,
                                      input logic [AxisW-1:0] au, av, hat);
    key_event_t                burst[$];
    key_event_t                ev;
    logic [AxisW-1:0]          axes[DigitalAxes];
    logic [DirectionCount-1:0] dirs;
    logic [MotionW-1:0]        mx;
    logic [MotionW-1:0]        my;
    int                        nbtn;
    int                        ndig;
    int                        thr;
    int                        off;
    axes = '{ax, ay, az, ar};
    nbtn = (button_count_q > ButtonW) ? ButtonW : int'(button_count_q);
    ndig = (axis_count_q < DigitalAxes) ? int'(axis_count_q) : DigitalAxes;
    thr  = int'(threshold_q);
    dirs = '0;

    for (int i = 0; i < nbtn; i++) begin
      if (btn[i] != prev_buttons_q[i]) burst.push_back(key_event(i, btn[i]));
    end
    prev_buttons_q = btn;

    for (int i = 0; i < ndig; i++) begin
      off = axis_offset(axes[i]);
      if (off < -thr) dirs[2*i] = 1'b1;
      else if (off > thr) dirs[2*i+1] = 1'b1;
    end

    if (has_hat_q && hat != HatCentred) begin
      if (hat == HatFwd) dirs[HatFwdBit] = 1'b1;
      else if (hat == HatBack) dirs[HatBackBit] = 1'b1;
      else if (hat == HatRight) dirs[HatRightBit] = 1'b1;
      else if (hat == HatLeft) dirs[HatLeftBit] = 1'b1;
    end

    for (int i = 0; i < DirectionCount; i++) begin
      if (dirs[i] != prev_dirs_q[i]) burst.push_back(key_event(ButtonW + i, dirs[i]));
    end
    prev_dirs_q = dirs;

    if (axis_count_q >= BallAxes) begin
      mx = scale_ball(au);
      my = scale_ball(av);
      if (mx != '0 || my != '0) begin
        ev      = '0;
        ev.kind = EV_MOTION;
        ev.mx   = mx;
        ev.my   = my;
        burst.push_back(ev);
      end
    end

    if (burst.size() > 0) begin
      ev      = burst.pop_back();
      ev.last = 1'b1;
      burst.push_back(ev);
    end
    foreach (burst[i]) events_due.push_back(burst[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    key_event_t want;
    if (!rst_ni) begin
      button_count_q = '0;
      axis_count_q   = '0;
      has_hat_q      = 1'b0;
      threshold_q    = ThresholdReset;
      ball_scale_q   = BallScaleReset;
      prev_buttons_q = '0;
      prev_dirs_q    = '0;
      events_due.delete();
      fails          = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (pop && !empty) begin
        if (events_due.size() == 0) begin
          fails++;
          if (fails <= MaxReports)
            $display("%0t: event with none expected: kind %0d src %0d pressed %0d mx %0d my %0d last %0d",
                     $time, event_kind_o, source_index_o, pressed_o, motion_x_o, motion_y_o, last_o);
        end else begin
          want = events_due.pop_front();
          if (want.kind !== event_kind_o || want.src !== source_index_o ||
              want.pressed !== pressed_o || want.mx !== motion_x_o ||
              want.my !== motion_y_o || want.last !== last_o) begin
            fails++;
            if (fails <= MaxReports) begin
              $display("%0t: event mismatch", $time);
              $display("  expected kind %0d src %0d pressed %0d mx %0d my %0d last %0d",
                       want.kind, want.src, want.pressed, $signed(want.mx), $signed(want.my),
                       want.last);
              $display("  actual   kind %0d src %0d pressed %0d mx %0d my %0d last %0d",
                       event_kind_o, source_index_o, pressed_o, motion_x_o, motion_y_o, last_o);
            end
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BUTTON_COUNT: button_count_q = cfg_wdata_i[BtnCountW-1:0];
          CFG_AXIS_COUNT:   axis_count_q   = cfg_wdata_i[AxCountW-1:0];
          CFG_HAS_HAT:      has_hat_q      = cfg_wdata_i[0];
          CFG_THRESHOLD:    threshold_q    = cfg_wdata_i[ThrW-1:0];
          CFG_BALL_SCALE:   ball_scale_q   = cfg_wdata_i[ScaleW-1:0];
          default: ;
        endcase
      end

      if (push && !full)
        decode_poll(buttons_i, axis_x_i, axis_y_i, axis_z_i, axis_r_i,
                    axis_u_i, axis_v_i, hat_angle_i);

      pending_o    <= events_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jpke_pkg::*;

  localparam logic [AxisW-1:0] AxisCentre  = 16'd32768;
  localparam logic [AxisW-1:0] HatCentred  = 16'hFFFF;
  localparam int               SettleCycles = 16;  // drain time after every predicted event is out
  localparam int               HoldCycles   = 400; // long receiver stall to fill the job queue

  // one poll sample as the sender builds it
  typedef struct packed {
    logic [ButtonW-1:0] buttons;
    logic [AxisW-1:0]   x;
    logic [AxisW-1:0]   y;
    logic [AxisW-1:0]   z;
    logic [AxisW-1:0]   r;
    logic [AxisW-1:0]   u;
    logic [AxisW-1:0]   v;
    logic [AxisW-1:0]   hat;
  } poll_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_idx_i;
  logic [CfgDataW-1:0]       cfg_wdata_i;
  logic                      push;
  logic                      full;
  logic [ButtonW-1:0]        buttons_i;
  logic [AxisW-1:0]          axis_x_i;
  logic [AxisW-1:0]          axis_y_i;
  logic [AxisW-1:0]          axis_z_i;
  logic [AxisW-1:0]          axis_r_i;
  logic [AxisW-1:0]          axis_u_i;
  logic [AxisW-1:0]          axis_v_i;
  logic [AxisW-1:0]          hat_angle_i;
  logic                      empty;
  logic                      pop;
  logic                      event_kind_o;
  logic [SrcW-1:0]           source_index_o;
  logic                      pressed_o;
  logic signed [MotionW-1:0] motion_x_o;
  logic signed [MotionW-1:0] motion_y_o;
  logic                      last_o;

  int    fail_count;
  int    pending;

  // sender-side view of the current settings, used to aim axes at the threshold
  int    cur_thr;
  poll_t last_poll;

  // long receiver stall, requested by the sender and timed by the receiver
  bit    hold_rx_req;
  bit    hold_rx_done;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  joystick_poll_to_key_events DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .buttons_i      (buttons_i),
    .axis_x_i       (axis_x_i),
    .axis_y_i       (axis_y_i),
    .axis_z_i       (axis_z_i),
    .axis_r_i       (axis_r_i),
    .axis_u_i       (axis_u_i),
    .axis_v_i       (axis_v_i),
    .hat_angle_i    (hat_angle_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .source_index_o (source_index_o),
    .pressed_o      (pressed_o),
    .motion_x_o     (motion_x_o),
    .motion_y_o     (motion_y_o),
    .last_o         (last_o)
  );

  // watches both channels and the register port, predicts and compares
  jpke_event_checker events_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .buttons_i      (buttons_i),
    .axis_x_i       (axis_x_i),
    .axis_y_i       (axis_y_i),
    .axis_z_i       (axis_z_i),
    .axis_r_i       (axis_r_i),
    .axis_u_i       (axis_u_i),
    .axis_v_i       (axis_v_i),
    .hat_angle_i    (hat_angle_i),
    .empty          (empty),
    .pop            (pop),
    .event_kind_o   (event_kind_o),
    .source_index_o (source_index_o),
    .pressed_o      (pressed_o),
    .motion_x_o     (motion_x_o),
    .motion_y_o     (motion_y_o),
    .last_o         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic poll_t mk_poll(input logic [ButtonW-1:0] btn,
                                    input logic [AxisW-1:0] x, y, z, r, u, v, hat);
    poll_t p;
    p.buttons = btn;
    p.x = x; p.y = y; p.z = z; p.r = r;
    p.u = u; p.v = v;
    p.hat = hat;
    return p;
  endfunction

  // held values, small moves near centre, hits just around both thresholds, the rails and random values
  function automatic logic [AxisW-1:0] pick_axis(input logic [AxisW-1:0] cur);
    logic [AxisW-1:0] a;
    case ($urandom_range(0, 7))
      0, 1:    a = cur;
      2:       a = AxisW'(AxisCentre + $urandom_range(0, 64) - 32);
      3:       a = AxisW'(AxisCentre + cur_thr + $urandom_range(0, 2) - 1);
      4:       a = AxisW'(AxisCentre - cur_thr + $urandom_range(0, 2) - 1);
      5:       a = $urandom_range(0, 1) ? '1 : '0;
      default: a = AxisW'($urandom());
    endcase
    return a;
  endfunction

  // well-formed poll with random content, built by changing fields of the last one
  function automatic poll_t next_random_poll();
    poll_t p;
    p = last_poll;
    case ($urandom_range(0, 4))
      0:       p.buttons = last_poll.buttons;
      1:       p.buttons = last_poll.buttons ^ (32'd1 << $urandom_range(0, 31));
      2:       p.buttons = last_poll.buttons ^ ($urandom() & $urandom() & $urandom());
      default: p.buttons = $urandom();
    endcase
    p.x = pick_axis(last_poll.x);
    p.y = pick_axis(last_poll.y);
    p.z = pick_axis(last_poll.z);
    p.r = pick_axis(last_poll.r);
    p.u = pick_axis(last_poll.u);
    p.v = pick_axis(last_poll.v);
    case ($urandom_range(0, 7))
      0:       p.hat = HatFwd;
      1:       p.hat = HatRight;
      2:       p.hat = HatBack;
      3:       p.hat = HatLeft;
      4:       p.hat = HatCentred;
      5:       p.hat = last_poll.hat;
      default: p.hat = AxisW'($urandom());
    endcase
    return p;
  endfunction

  // drive one sample and hold it until the transfer edge
  task automatic send_poll(input poll_t p);
    push        <= 1'b1;
    buttons_i   <= p.buttons;
    axis_x_i    <= p.x;
    axis_y_i    <= p.y;
    axis_z_i    <= p.z;
    axis_r_i    <= p.r;
    axis_u_i    <= p.u;
    axis_v_i    <= p.v;
    hat_angle_i <= p.hat;
    last_poll    = p;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(input int btn, input int axes, input bit hat,
                            input int thr, input int scale);
    write_reg(CFG_BUTTON_COUNT, CfgDataW'(btn));
    write_reg(CFG_AXIS_COUNT, CfgDataW'(axes));
    write_reg(CFG_HAS_HAT, CfgDataW'(hat));
    write_reg(CFG_THRESHOLD, CfgDataW'(thr));
    write_reg(CFG_BALL_SCALE, CfgDataW'(scale));
    cur_thr = thr & 16'hFFFF;
  endtask

  // sender goes quiet until every predicted event is out, then lets the
  // front stage drain samples that produced nothing
  task automatic quiesce();
    push <= 1'b0;
    // wait for an edge so the pending count includes the last transfer
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // bursts of back-to-back samples separated by random gaps, some of them zero
  task automatic run_random(input int count);
    int burst;
    int gap;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 10);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      send_poll(next_random_poll());
      burst--;
    end
  endtask

  task automatic run_phase(input int btn, input int axes, input bit hat,
                           input int thr, input int scale, input int count);
    set_config(btn, axes, hat, thr, scale);
    run_random(count);
    quiesce();
  endtask

  // receiver: pop pattern changes after a random span, plus one long hold
  initial begin : result_drain
    int mode;
    int span;
    int tick;
    pop  <= 1'b0;
    tick  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(posedge clk_i);
        tick++;
        if (hold_rx_req && !hold_rx_done) begin
          pop <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
          hold_rx_done = 1'b1;
        end else begin
          case (mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) == 0);
            2:       pop <= 1'($urandom_range(0, 1));
            default: pop <= ((tick % 8) < 5);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_BUTTON_COUNT;
    cfg_wdata_i <= '0;
    push        <= 1'b0;
    buttons_i   <= '0;
    axis_x_i    <= AxisCentre;
    axis_y_i    <= AxisCentre;
    axis_z_i    <= AxisCentre;
    axis_r_i    <= AxisCentre;
    axis_u_i    <= AxisCentre;
    axis_v_i    <= AxisCentre;
    hat_angle_i <= HatCentred;
    last_poll    = mk_poll('0, AxisCentre, AxisCentre, AxisCentre, AxisCentre,
                           AxisCentre, AxisCentre, HatCentred);
    cur_thr      = int'(ThresholdReset);
    hold_rx_req  = 1'b0;
    hold_rx_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full device: every button, four digital axes, ball and hat
    set_config(32, 6, 1'b1, int'(ThresholdReset), int'(BallScaleReset));
    // all buttons pressed, axes on the low rail, hat forward
    send_poll(mk_poll('1, '0, '0, '0, '0, '0, '0, HatFwd));
    // everything flips: releases, opposite directions, hat back
    send_poll(mk_poll('0, '1, '1, '1, '1, '1, '1, HatBack));
    // same keys and directions, ball centred: no events at all
    send_poll(mk_poll('0, '1, '1, '1, '1, AxisCentre, AxisCentre, HatBack));
    // offsets exactly at the threshold set nothing; tiny ball motion
    send_poll(mk_poll('0, AxisCentre + 16'd4915, AxisCentre - 16'd4915, AxisCentre,
                      AxisCentre, AxisCentre + 16'd50, AxisCentre - 16'd1, HatRight));
    // one step past the threshold; ball offset too small to survive scaling
    send_poll(mk_poll('0, AxisCentre + 16'd4916, AxisCentre - 16'd4916, AxisCentre,
                      AxisCentre, AxisCentre + 16'd1, AxisCentre, HatLeft));
    // odd hat angle, then centred hat
    send_poll(mk_poll(32'hA5A5A5A5, AxisCentre, AxisCentre, '0, '1,
                      AxisCentre, 16'd0, 16'd4500));
    send_poll(mk_poll(32'h5A5A5A5A, AxisCentre, AxisCentre, '1, '0,
                      16'd0, AxisCentre, HatCentred));
    quiesce();

    // button count past 32, every axis bit set, threshold out of reach, largest scale
    set_config(63, 31, 1'b1, 32768, 24'hFFFFFF);
    send_poll(mk_poll('1, '0, '1, '0, '1, '0, '1, HatFwd));
    send_poll(mk_poll('0, '1, '0, '1, '0, '1, '0, HatBack));
    quiesce();
    write_reg(CFG_THRESHOLD, CfgDataW'(16'hFFFF));
    cur_thr = 16'hFFFF;
    send_poll(mk_poll(32'h80000001, '0, '0, '1, '1, '1, '1, HatRight));
    quiesce();

    // few buttons examined, three axes, hat off, zero threshold, zero scale
    set_config(5, 3, 1'b0, 0, 0);
    send_poll(mk_poll('1, AxisCentre + 16'd1, AxisCentre - 16'd1, AxisCentre,
                      '0, '0, '1, HatFwd));
    send_poll(mk_poll(32'h0000001F, AxisCentre, AxisCentre, AxisCentre + 16'd1,
                      '1, '1, '0, HatLeft));
    send_poll(mk_poll(32'hFFFFFFE0, AxisCentre - 16'd1, AxisCentre + 16'd1,
                      AxisCentre - 16'd1, AxisCentre, AxisCentre, AxisCentre, HatBack));
    quiesce();

    // no buttons, four digital axes and the hat, no ball
    set_config(0, 4, 1'b1, int'(ThresholdReset), int'(BallScaleReset));
    send_poll(mk_poll('1, '0, '1, '0, '1, '0, '0, HatRight));
    send_poll(mk_poll(32'h12345678, '1, '0, '1, '0, '1, '1, HatRight));
    send_poll(mk_poll('0, AxisCentre, AxisCentre, AxisCentre, AxisCentre,
                      '0, '0, HatCentred));
    quiesce();

    // no axes: only buttons and the hat
    set_config(32, 0, 1'b1, int'(ThresholdReset), int'(BallScaleReset));
    send_poll(mk_poll(32'h00000001, '0, '0, '0, '0, '0, '0, HatLeft));
    send_poll(mk_poll(32'h80000000, '1, '1, '1, '1, '1, '1, HatFwd));
    send_poll(mk_poll(32'h80000000, '1, '1, '1, '1, '1, '1, 16'd27001));
    quiesce();

    // five axes: all four digital, still no ball
    set_config(32, 5, 1'b1, int'(ThresholdReset), int'(BallScaleReset));
    send_poll(mk_poll(32'hFFFF0000, '0, '1, AxisCentre, '0, '0, '1, HatRight));
    quiesce();

    // random part; the first phase runs into the long receiver hold so the
    // job queue fills and full pushes back on the sender
    hold_rx_req = 1'b1;
    run_phase(32, 6, 1'b1, int'(ThresholdReset), int'(BallScaleReset), 20);
    run_phase($urandom_range(0, 63), $urandom_range(0, 31), 1'($urandom_range(0, 1)),
              $urandom_range(0, 8000), $urandom_range(0, 24'hFFFFFF), 15);
    run_phase(32, 6, 1'b1, $urandom_range(0, 20000), 24'hFFFFFF, 15);
    run_phase(16, 4, 1'b0, 0, 0, 15);
    run_phase($urandom_range(0, 63), $urandom_range(0, 31), 1'($urandom_range(0, 1)),
              $urandom_range(0, 65535), $urandom_range(0, 24'hFFFFFF), 15);
    run_phase(32, 7, 1'b1, 32768, int'(BallScaleReset), 10);

    if (fail_count == 0 && pending == 0) begin
      $display("joystick_poll_to_key_events verification clean");
    end else begin
      $display("joystick_poll_to_key_events verification failed");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("joystick_poll_to_key_events verification failed");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/jpke_pkg.sv
hw/rtl/jpke_front.sv
hw/rtl/jpke_fifo.sv
hw/rtl/jpke_back.sv
hw/rtl/joystick_poll_to_key_events.sv
bench/jpke_event_checker.sv
bench/tb_top.sv
